// ===== rtl/core/gpx_pkg.sv =====
// Shared types and constants for the GPIO expander register core.
// Holds the request and response word structs, access mode codes and the register map.
// No dependencies; every other file in rtl/core imports this package.
package gpx_pkg;

  // Number of implemented ports, 1 to 8.
  localparam int PORT_COUNT = 8;
  localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  // Number of drive-mode banks and the width of a per-pin bank code.
  localparam int BANK_COUNT = 7;
  localparam int BANK_CODE_W = 3;
  localparam int DRV_ROW_W = 8 * BANK_CODE_W;

  // Seven-bit bus address of the device.
  localparam logic [6:0] DEV_ADDR = 7'h20;

  // Register map.
  localparam logic [7:0] REG_OUT_BASE = 8'h08;
  localparam logic [7:0] REG_OUT_END  = 8'h10;
  localparam logic [7:0] REG_PORT_SEL = 8'h18;
  localparam logic [7:0] REG_DIR      = 8'h1C;
  localparam logic [7:0] REG_DRV_BASE = 8'h1D;
  localparam logic [7:0] REG_DRV_END  = 8'h24;
  localparam logic [7:0] REG_DEV_ID   = 8'h2E;
  localparam logic [7:0] DEV_ID_VALUE = 8'h60;
  localparam logic [2:0] PORT_SEL_MASK = 3'h7;

  // Reset values.
  localparam logic [7:0] DIR_RESET = 8'hFF;
  localparam logic [BANK_CODE_W-1:0] BANK_PULLUP = '0;

  // Access modes carried by a request word.
  typedef enum logic [1:0] {
    MODE_PTR_WRITE  = 2'd0,
    MODE_DATA_WRITE = 2'd1,
    MODE_DATA_READ  = 2'd2,
    MODE_RESET_LINE = 2'd3
  } mode_t;

  // One request word.
  typedef struct packed {
    mode_t       mode;
    logic [6:0]  bus_address;
    logic [7:0]  data;
    logic        reset_line;
    logic [63:0] pin_levels;
  } req_t;

  // One response word.
  typedef struct packed {
    logic        ack;
    logic [7:0]  read_data;
    logic [63:0] sampled_inputs;
    logic        was_accessed;
  } rsp_t;

endpackage

// ===== rtl/core/gpx_req_stage.sv =====
// Request input register for the GPIO expander register core.
// Depends on gpx_pkg for the request word type.
module gpx_req_stage
  import gpx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  input  logic advance,
  output logic held_valid,
  output req_t held
);

  // Hold off the sender only while a word waits here and the next stage is full and stalled.
  assign req_stall = held_valid && !advance;

  // Load a new word whenever this register is empty or is being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || advance) begin
      held_valid <= req_valid;
    end
    if (!held_valid || advance) begin
      held <= req;
    end
  end

endmodule

// ===== rtl/core/gpx_regs.sv =====
// Register file and access decode for the GPIO expander register core.
// Applies one request word per cycle, unless stalled, to the register state; forms its response word.
// Depends on gpx_pkg for the word types, access modes and register map.
module gpx_regs
  import gpx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp_next
);

  // Architectural state.
  logic                 bus_enabled;
  logic [7:0]           reg_ptr;
  logic [2:0]           port_sel;
  logic [63:0]          captured_inputs;
  logic                 accessed_flag;
  logic                 reset_held;
  logic [7:0]           output_latches [PORT_COUNT];
  logic [7:0]           port_directions [PORT_COUNT];
  // Each pin sits in exactly one drive-mode bank, so a port keeps one bank code per pin.
  logic [DRV_ROW_W-1:0] drive_codes [PORT_COUNT];

  logic [7:0]  reg_ptr_next;
  logic [2:0]  port_sel_next;
  logic [63:0] captured_inputs_next;
  logic        accessed_flag_next;
  logic        reset_held_next;

  logic                   hit;
  logic                   restore;
  logic                   sp_ok;
  logic [PORT_IDX_W-1:0]  sp_idx;
  logic [2:0]             ptr_port;
  logic                   ptr_port_ok;
  logic [PORT_IDX_W-1:0]  ptr_idx;
  logic                   is_input_reg;
  logic                   is_latch_reg;
  logic                   is_drv_reg;
  logic [BANK_CODE_W-1:0] bank;
  logic [DRV_ROW_W-1:0]   drv_cur;
  logic [DRV_ROW_W-1:0]   drv_wdata;
  logic [7:0]             bank_bits;
  logic [7:0]             read_byte;
  logic                   latch_we;
  logic                   dir_we;
  logic                   drv_we;

  // Address decode of the current pointer and the selected port.
  assign sp_ok        = int'(port_sel) < PORT_COUNT;
  assign sp_idx       = port_sel[PORT_IDX_W-1:0];
  assign ptr_port     = reg_ptr[2:0];
  assign ptr_port_ok  = int'(ptr_port) < PORT_COUNT;
  assign ptr_idx      = reg_ptr[PORT_IDX_W-1:0];
  assign is_input_reg = reg_ptr < REG_OUT_BASE;
  assign is_latch_reg = (reg_ptr >= REG_OUT_BASE) && (reg_ptr < REG_OUT_END);
  assign is_drv_reg   = (reg_ptr >= REG_DRV_BASE) && (reg_ptr < REG_DRV_END);
  assign bank         = BANK_CODE_W'(reg_ptr - REG_DRV_BASE);
  assign drv_cur      = drive_codes[sp_idx];

  // Bank view for a read, and the new bank codes for a write: the written bits
  // move into the addressed bank, which also drops them from every other bank.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bank_bits[i] = drv_cur[i*BANK_CODE_W +: BANK_CODE_W] == bank;
      drv_wdata[i*BANK_CODE_W +: BANK_CODE_W] =
        req.data[i] ? bank : drv_cur[i*BANK_CODE_W +: BANK_CODE_W];
    end
  end

  // Read mux over the register map.
  always_comb begin
    read_byte = 8'h00;
    if (is_input_reg) begin
      if (ptr_port_ok) begin
        read_byte = req.pin_levels[{ptr_port, 3'b000} +: 8];
      end
    end else if (is_latch_reg) begin
      if (ptr_port_ok) begin
        read_byte = output_latches[ptr_idx];
      end
    end else if (reg_ptr == REG_PORT_SEL) begin
      read_byte = {5'b00000, port_sel};
    end else if (reg_ptr == REG_DIR) begin
      if (sp_ok) begin
        read_byte = port_directions[sp_idx];
      end
    end else if (is_drv_reg) begin
      if (sp_ok) begin
        read_byte = bank_bits;
      end
    end else if (reg_ptr == REG_DEV_ID) begin
      read_byte = DEV_ID_VALUE;
    end
  end

  // The device answers a bus access only when addressed, enabled and out of reset.
  assign hit = (req.mode != MODE_RESET_LINE) && (req.bus_address == DEV_ADDR) &&
               bus_enabled && !reset_held;

  // Next-state and response for the word in the input register.
  always_comb begin
    reg_ptr_next          = reg_ptr;
    port_sel_next         = port_sel;
    captured_inputs_next  = captured_inputs;
    accessed_flag_next    = accessed_flag;
    reset_held_next       = reset_held;
    restore               = 1'b0;
    latch_we              = 1'b0;
    dir_we                = 1'b0;
    drv_we                = 1'b0;
    rsp_next.read_data    = 8'h00;
    if (fire) begin
      if (req.mode == MODE_RESET_LINE) begin
        if (req.reset_line) begin
          restore = 1'b1;
        end else begin
          reset_held_next = 1'b0;
        end
      end else if (hit) begin
        accessed_flag_next = 1'b1;
        unique case (req.mode)
          MODE_PTR_WRITE: begin
            reg_ptr_next = req.data;
          end
          MODE_DATA_WRITE: begin
            reg_ptr_next = reg_ptr + 8'd1;
            if (is_latch_reg) begin
              latch_we = ptr_port_ok;
            end else if (reg_ptr == REG_PORT_SEL) begin
              port_sel_next = req.data[2:0] & PORT_SEL_MASK;
            end else if (reg_ptr == REG_DIR) begin
              dir_we = sp_ok;
            end else if (is_drv_reg) begin
              drv_we = sp_ok;
            end
          end
          MODE_DATA_READ: begin
            reg_ptr_next       = reg_ptr + 8'd1;
            rsp_next.read_data = read_byte;
            if (is_input_reg) begin
              captured_inputs_next = req.pin_levels;
            end
          end
          default: begin
            reg_ptr_next = reg_ptr;
          end
        endcase
      end
    end
    // A reset-line pulse returns every device register to its default; the host bus enable keeps its value.
    if (restore) begin
      reg_ptr_next          = 8'h00;
      port_sel_next         = 3'd0;
      captured_inputs_next  = 64'd0;
      accessed_flag_next    = 1'b0;
      reset_held_next       = 1'b1;
    end
    rsp_next.ack            = hit;
    rsp_next.sampled_inputs = captured_inputs_next;
    rsp_next.was_accessed   = accessed_flag_next;
  end

  // Scalar registers and the host bus enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_enabled      <= 1'b0;
      reg_ptr          <= 8'h00;
      port_sel         <= 3'd0;
      captured_inputs  <= 64'd0;
      accessed_flag    <= 1'b0;
      reset_held       <= 1'b1;
    end else begin
      if (cfg_write) begin
        bus_enabled <= cfg_data;
      end
      reg_ptr          <= reg_ptr_next;
      port_sel         <= port_sel_next;
      captured_inputs  <= captured_inputs_next;
      accessed_flag    <= accessed_flag_next;
      reset_held       <= reset_held_next;
    end
  end

  // Per-port latches, directions and drive-mode codes.
  always_ff @(posedge clk) begin
    if (rst || restore) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        output_latches[p]  <= 8'h00;
        port_directions[p] <= DIR_RESET;
        drive_codes[p]     <= {8{BANK_PULLUP}};
      end
    end else begin
      if (latch_we) begin
        output_latches[ptr_idx] <= req.data;
      end
      if (dir_we) begin
        port_directions[sp_idx] <= req.data;
      end
      if (drv_we) begin
        drive_codes[sp_idx] <= drv_wdata;
      end
    end
  end

endmodule

// ===== rtl/core/gpx_rsp_stage.sv =====
// Response output register for the GPIO expander register core.
// Depends on gpx_pkg for the response word type.
module gpx_rsp_stage
  import gpx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  rsp_t load,
  output logic advance,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // The register takes a new word when empty or when its word leaves this cycle.
  assign advance = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= load_valid;
    end
    if (advance) begin
      rsp <= load;
    end
  end

endmodule

// ===== rtl/core/i2c_gpio_expander_registers_core.sv =====
// Top level of the GPIO expander register core.
// Depends on gpx_pkg, gpx_req_stage, gpx_regs and gpx_rsp_stage.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one word per bus byte access
//   or reset-line event. A word is taken at a clock edge with req_valid high
//   and req_stall low.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one word per request,
//   in order, taken at an edge with rsp_valid high and rsp_stall low.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the host
//   bus enable bit; cfg_ready is always high. Write it only while idle.
// Timing:
//   The edge that accepts a request loads the input register; once the
//   output register can take a word, the decoded response is loaded into it
//   and rsp_valid rises. Throughput is one word per cycle unless rsp_stall
//   holds a full output register; each word's register update completes
//   in the same cycle it is decoded, so the next word sees it directly.
// Reset and stalls:
//   rst empties both registers and restores every register default, with the
//   bus disabled. While rsp_stall holds a full output register, the input
//   register still takes one more word, then req_stall rises.
module i2c_gpio_expander_registers_core
  import gpx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic held_valid;
  req_t held;
  logic advance;
  rsp_t rsp_next;

  assign cfg_ready = 1'b1;

  gpx_req_stage u_req_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  gpx_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (held_valid && advance),
    .req       (held),
    .rsp_next  (rsp_next)
  );

  gpx_rsp_stage u_rsp_stage (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load       (rsp_next),
    .advance    (advance),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// ===== rtl/core/gpx_checker.sv =====
// Port-level checks for the GPIO expander register core, bound to the top level.
// Depends on gpx_pkg for the word types.
module gpx_checker
  import gpx_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled response word stays put.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // Reset empties the response register.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A refused access returns no data.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ack |-> rsp.read_data == 8'h00)
    else $error("read data on an unacknowledged access");

  // An acknowledged access always leaves the accessed flag set.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.ack |-> rsp.was_accessed)
    else $error("acknowledged access without accessed flag");

  // The request side backs up only behind a stalled response.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_stall && rsp_valid)
    else $error("request stalled without a stalled response");

endmodule

bind i2c_gpio_expander_registers_core gpx_checker u_gpx_checker (.*);
